// ----- rtl/core/mcst_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer pool package
// Shared constants, command and result codes, sequencer states and the
// layout of one timer memory entry.
// ----------------------------------------------------------------------------
package mcst_pkg;

  // Number of timer slots in the pool (1..31).
  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  localparam int MODE_W   = 3;
  localparam int HANDLE_W = 5;
  localparam int PERIOD_W = 32;
  localparam int REPEAT_W = 16;
  localparam int KIND_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_RESTART = 3'd4,
    CMD_RESUME  = 3'd5,
    CMD_DELETE  = 3'd6,
    CMD_QUERY   = 3'd7
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DONE    = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_TICKED  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_RELOAD,
    ST_TICK_END
  } state_t;

  // One timer's counter and repeat value, as held in either memory.
  typedef struct packed {
    logic [PERIOD_W-1:0] count;
    logic [REPEAT_W-1:0] repeats;
  } entry_t;

endpackage

// ----- rtl/core/multi_channel_soft_timer_pool.sv -----
// ----------------------------------------------------------------------------
// Multi-channel soft timer pool
// A pool of down-counting timers with reload and repeat count, driven by
// one command request at a time and reporting command completions, timer
// expiries and tick completion on the result channel.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  ---------------------------------
//  in_*      input      in_valid/in_stall   mode, handle, period, repeat_count
//  out_*     output     out_valid/out_stall kind, timer_id, running, error, last
//
// Every command except tick and reload-type commands completes in the cycle
// its request is accepted; a restart of a used timer, or a resume of a stopped
// one, reads the stored reload values from memory and then writes them back.
// A tick walks the slots one per cycle from a pipelined memory read, except
// while an expiry waits on out_stall; the tick-finished result likewise waits
// on out_stall once the last slot is done.
// Reset clears the used and running flags; the counter memories hold no
// reset value; their contents only matter for slots written by create.
// A request is taken only when the sequencer is idle and the output register
// can accept a result, so a held output stalls the input side.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_pool (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mcst_pkg::MODE_W-1:0]          in_mode,
  input  logic [mcst_pkg::HANDLE_W-1:0]        in_handle,
  input  logic [mcst_pkg::PERIOD_W-1:0]        in_period,
  input  logic signed [mcst_pkg::REPEAT_W-1:0] in_repeat_count,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mcst_pkg::KIND_W-1:0]          out_kind,
  output logic [mcst_pkg::HANDLE_W-1:0]        out_timer_id,
  output logic                                 out_running,
  output logic                                 out_error,
  output logic                                 out_last
);

  localparam int N  = mcst_pkg::TIMER_SLOTS;
  localparam int SW = mcst_pkg::SLOT_W;
  localparam int HW = mcst_pkg::HANDLE_W;

  // Two memories: the live count and repeats left, and the reload values.
  mcst_pkg::entry_t mem_live [N];
  mcst_pkg::entry_t mem_init [N];

  mcst_pkg::entry_t live_rd_r;
  mcst_pkg::entry_t init_rd_r;

  mcst_pkg::state_t state_r, state_nxt;
  logic [N-1:0]     used_r, used_nxt;
  logic [N-1:0]     running_r, running_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;

  logic             out_valid_r;
  mcst_pkg::kind_t  out_kind_r;
  logic [HW-1:0]    out_id_r;
  logic             out_run_r;
  logic             out_err_r;
  logic             out_last_r;

  // Memory port controls.
  logic             rd_en;
  logic [SW-1:0]    rd_addr;
  logic             live_we;
  logic [SW-1:0]    live_waddr;
  mcst_pkg::entry_t live_wdata;
  logic             init_we;

  // Result emission.
  logic             emit;
  mcst_pkg::kind_t  em_kind;
  logic [HW-1:0]    em_id;
  logic             em_run;
  logic             em_err;
  logic             em_last;

  mcst_pkg::mode_t  cmd;
  logic             accept;
  logic             out_free;
  logic [HW:0]      handle_m1;
  logic [SW-1:0]    hslot;
  logic             handle_ok;
  logic             go_reload;

  logic             free_found;
  logic [SW-1:0]    free_idx;

  logic                     tick_act;
  logic [mcst_pkg::PERIOD_W-1:0] tick_dec;
  logic                     tick_expire;
  logic                     tick_adv;
  logic                     tick_last_slot;

  assign cmd       = mcst_pkg::mode_t'(in_mode);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == mcst_pkg::ST_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;

  // Handle 1..N maps to slot 0..N-1.
  assign handle_m1 = {1'b0, in_handle} - {{HW{1'b0}}, 1'b1};
  assign hslot     = SW'(handle_m1);
  assign handle_ok = (in_handle != '0) && (int'(in_handle) <= N);

  // Restart reloads a used slot; resume does so only for a stopped one.
  assign go_reload = used_r[hslot] &&
                     ((cmd == mcst_pkg::CMD_RESTART) ||
                      ((cmd == mcst_pkg::CMD_RESUME) && !running_r[hslot]));

  // Lowest free slot for create.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = N - 1; s >= 0; s--) begin
      if (!used_r[s]) begin
        free_found = 1'b1;
        free_idx   = SW'(s);
      end
    end
  end

  // Tick work on the slot whose entry was last read from memory.
  assign tick_act       = used_r[idx_r] && running_r[idx_r];
  assign tick_dec       = (live_rd_r.count != '0) ? live_rd_r.count - 1'b1 : live_rd_r.count;
  assign tick_expire    = (tick_dec == '0);
  assign tick_adv       = !tick_act || !tick_expire || out_free;
  assign tick_last_slot = (idx_r == SW'(N - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcst_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd == mcst_pkg::CMD_TICK) begin
            state_nxt = mcst_pkg::ST_TICK;
          end else if ((cmd != mcst_pkg::CMD_CREATE) && handle_ok && go_reload) begin
            state_nxt = mcst_pkg::ST_RELOAD;
          end
        end
      end
      mcst_pkg::ST_TICK: begin
        if (tick_adv && tick_last_slot) begin
          state_nxt = mcst_pkg::ST_TICK_END;
        end
      end
      mcst_pkg::ST_RELOAD: begin
        if (out_free) begin
          state_nxt = mcst_pkg::ST_IDLE;
        end
      end
      mcst_pkg::ST_TICK_END: begin
        if (out_free) begin
          state_nxt = mcst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcst_pkg::ST_IDLE;
    endcase
  end

  // Datapath, flag updates, memory controls and result emission.
  always_comb begin
    used_nxt    = used_r;
    running_nxt = running_r;
    idx_nxt     = idx_r;
    rd_en       = 1'b0;
    rd_addr     = idx_r;
    live_we     = 1'b0;
    live_waddr  = idx_r;
    live_wdata  = live_rd_r;
    init_we     = 1'b0;
    emit        = 1'b0;
    em_kind     = mcst_pkg::KIND_DONE;
    em_id       = '0;
    em_run      = 1'b0;
    em_err      = 1'b0;
    em_last     = 1'b1;

    unique case (state_r)
      mcst_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd == mcst_pkg::CMD_TICK) begin
            idx_nxt = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
          end else if (cmd == mcst_pkg::CMD_CREATE) begin
            emit = 1'b1;
            if (free_found) begin
              live_we              = 1'b1;
              init_we              = 1'b1;
              live_waddr           = free_idx;
              live_wdata.count     = in_period;
              live_wdata.repeats   = in_repeat_count;
              used_nxt[free_idx]   = 1'b1;
              running_nxt[free_idx] = 1'b0;
              em_id                = HW'(free_idx) + 1'b1;
            end
          end else if (!handle_ok) begin
            emit   = 1'b1;
            em_err = 1'b1;
          end else begin
            unique case (cmd)
              mcst_pkg::CMD_START: begin
                emit = 1'b1;
                if (used_r[hslot]) begin
                  running_nxt[hslot] = 1'b1;
                end
              end
              mcst_pkg::CMD_STOP: begin
                emit               = 1'b1;
                running_nxt[hslot] = 1'b0;
              end
              mcst_pkg::CMD_DELETE: begin
                emit            = 1'b1;
                used_nxt[hslot] = 1'b0;
              end
              mcst_pkg::CMD_QUERY: begin
                emit   = 1'b1;
                em_run = running_r[hslot];
              end
              mcst_pkg::CMD_RESTART, mcst_pkg::CMD_RESUME: begin
                if (go_reload) begin
                  // Fetch the reload values; the write-back follows.
                  idx_nxt = hslot;
                  rd_en   = 1'b1;
                  rd_addr = hslot;
                end else begin
                  emit = 1'b1;
                end
              end
              mcst_pkg::CMD_TICK, mcst_pkg::CMD_CREATE: begin
                emit = 1'b0;
              end
            endcase
          end
        end
      end

      mcst_pkg::ST_TICK: begin
        if (tick_act) begin
          if (!tick_expire) begin
            live_we            = 1'b1;
            live_wdata.count   = tick_dec;
            live_wdata.repeats = live_rd_r.repeats;
          end else if (out_free) begin
            live_we            = 1'b1;
            live_wdata.count   = init_rd_r.count;
            live_wdata.repeats = live_rd_r.repeats;
            if ($signed(live_rd_r.repeats) == 16'sd1) begin
              running_nxt[idx_r] = 1'b0;
            end else if ($signed(live_rd_r.repeats) > 16'sd1) begin
              live_wdata.repeats = live_rd_r.repeats - 1'b1;
            end
            emit    = 1'b1;
            em_kind = mcst_pkg::KIND_EXPIRED;
            em_id   = HW'(idx_r) + 1'b1;
            em_last = 1'b0;
          end
        end
        // Read the next slot while this one is written back.
        if (tick_adv && !tick_last_slot) begin
          idx_nxt = idx_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end

      mcst_pkg::ST_RELOAD: begin
        if (out_free) begin
          live_we            = 1'b1;
          live_wdata         = init_rd_r;
          running_nxt[idx_r] = 1'b1;
          emit               = 1'b1;
        end
      end

      mcst_pkg::ST_TICK_END: begin
        if (out_free) begin
          emit    = 1'b1;
          em_kind = mcst_pkg::KIND_TICKED;
        end
      end

      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Memories: one write port each, registered read.
  always_ff @(posedge clk) begin
    if (live_we) begin
      mem_live[live_waddr] <= live_wdata;
    end
    if (init_we) begin
      mem_init[live_waddr] <= live_wdata;
    end
    if (rd_en) begin
      live_rd_r <= mem_live[rd_addr];
      init_rd_r <= mem_init[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcst_pkg::ST_IDLE;
      used_r      <= '0;
      running_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      running_r <= running_nxt;
      idx_r     <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register; only loaded when the register is free.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= em_kind;
      out_id_r   <= em_id;
      out_run_r  <= em_run;
      out_err_r  <= em_err;
      out_last_r <= em_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_timer_id = out_id_r;
  assign out_running  = out_run_r;
  assign out_error    = out_err_r;
  assign out_last     = out_last_r;

endmodule

// ----- tb/multi_channel_soft_timer_pool_tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the multi-channel soft timer pool
// Sends command requests (create, start, stop, restart, resume, delete,
// query, tick) through the valid/stall input channel. A behavioral copy of
// the pool predicts every result, and each accepted result is checked
// against the oldest prediction. Both sides throttle at random, and the
// receiver also holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_pool_tb;
  import mcst_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int CYCLE_LIMIT = 400000;
  // Length of the long receiver hold-off used to fill the block up.
  localparam int LONG_HOLD = 200;

  // One result as seen on the output channel.
  typedef struct packed {
    kind_t                 kind;
    logic [HANDLE_W-1:0]   timer_id;
    logic                  running;
    logic                  error;
    logic                  last;
  } result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [MODE_W-1:0]           in_mode;
  logic [HANDLE_W-1:0]         in_handle;
  logic [PERIOD_W-1:0]         in_period;
  logic signed [REPEAT_W-1:0]  in_repeat_count;
  logic                        out_valid;
  logic                        out_stall;
  logic [KIND_W-1:0]           out_kind;
  logic [HANDLE_W-1:0]         out_timer_id;
  logic                        out_running;
  logic                        out_error;
  logic                        out_last;

  // Results predicted but not yet seen, oldest first.
  result_t pending_results[$];
  int      error_count;
  int      cycle_count;

  // Throttling controls shared by the stimulus and the stall process.
  bit quiet;
  bit sender_gaps;
  bit hold_request;
  int stall_left;

  // Behavioral copy of the timer pool.
  bit                         pool_used[TIMER_SLOTS];
  bit                         pool_running[TIMER_SLOTS];
  logic [PERIOD_W-1:0]        pool_count[TIMER_SLOTS];
  logic [PERIOD_W-1:0]        pool_reload[TIMER_SLOTS];
  logic signed [REPEAT_W-1:0] pool_reps_left[TIMER_SLOTS];
  logic signed [REPEAT_W-1:0] pool_reps_init[TIMER_SLOTS];

  multi_channel_soft_timer_pool u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_handle       (in_handle),
    .in_period       (in_period),
    .in_repeat_count (in_repeat_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_timer_id    (out_timer_id),
    .out_running     (out_running),
    .out_error       (out_error),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multi_channel_soft_timer_pool_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic push_result(kind_t kind, logic [HANDLE_W-1:0] id, logic running,
                             logic error, logic last);
    result_t r;
    r.kind     = kind;
    r.timer_id = id;
    r.running  = running;
    r.error    = error;
    r.last     = last;
    pending_results.push_back(r);
  endtask

  // Reload a used slot from its stored period and repeat count and run it.
  task automatic pool_rearm(int s);
    if (pool_used[s]) begin
      pool_count[s]     = pool_reload[s];
      pool_reps_left[s] = pool_reps_init[s];
      pool_running[s]   = 1'b1;
    end
  endtask

  // Apply one accepted request to the pool copy and queue its results.
  task automatic pool_predict(mode_t mode, logic [HANDLE_W-1:0] handle,
                              logic [PERIOD_W-1:0] period,
                              logic signed [REPEAT_W-1:0] reps);
    int s;
    if (mode == CMD_TICK) begin
      // Every used and running slot counts down; a count that reaches zero
      // reloads, spends one repeat and reports an expiry.
      for (s = 0; s < TIMER_SLOTS; s++) begin
        if (pool_used[s] && pool_running[s]) begin
          if (pool_count[s] != 0) pool_count[s] = pool_count[s] - 1;
          if (pool_count[s] == 0) begin
            pool_count[s] = pool_reload[s];
            if (pool_reps_left[s] == 1) pool_running[s] = 1'b0;
            else if (pool_reps_left[s] > 1) pool_reps_left[s] = pool_reps_left[s] - 1;
            push_result(KIND_EXPIRED, HANDLE_W'(s + 1), 1'b0, 1'b0, 1'b0);
          end
        end
      end
      push_result(KIND_TICKED, '0, 1'b0, 1'b0, 1'b1);
    end else if (mode == CMD_CREATE) begin
      for (s = 0; s < TIMER_SLOTS; s++) begin
        if (!pool_used[s]) break;
      end
      if (s == TIMER_SLOTS) begin
        push_result(KIND_DONE, '0, 1'b0, 1'b0, 1'b1);
      end else begin
        pool_used[s]      = 1'b1;
        pool_running[s]   = 1'b0;
        pool_reload[s]    = period;
        pool_count[s]     = period;
        pool_reps_init[s] = reps;
        pool_reps_left[s] = reps;
        push_result(KIND_DONE, HANDLE_W'(s + 1), 1'b0, 1'b0, 1'b1);
      end
    end else if (handle == 0 || handle > TIMER_SLOTS) begin
      push_result(KIND_DONE, '0, 1'b0, 1'b1, 1'b1);
    end else begin
      s = handle - 1;
      case (mode)
        CMD_START: begin
          if (pool_used[s]) pool_running[s] = 1'b1;
        end
        CMD_STOP: begin
          pool_running[s] = 1'b0;
        end
        CMD_RESTART: begin
          pool_rearm(s);
        end
        CMD_RESUME: begin
          if (!pool_running[s]) pool_rearm(s);
        end
        CMD_DELETE: begin
          // The running flag is deliberately left alone.
          pool_used[s] = 1'b0;
        end
        default: begin
        end
      endcase
      push_result(KIND_DONE, '0, (mode == CMD_QUERY) ? pool_running[s] : 1'b0,
                  1'b0, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind     = kind_t'(out_kind);
      got.timer_id = out_timer_id;
      got.running  = out_running;
      got.error    = out_error;
      got.last     = out_last;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result kind=%0d id=%0d running=%0b error=%0b last=%0b",
                 $time, got.kind, got.timer_id, got.running, got.error, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          error_count++;
          $display("%0t: result mismatch: expected kind=%0d id=%0d running=%0b error=%0b last=%0b",
                   $time, want.kind, want.timer_id, want.running, want.error, want.last);
          $display("%0t:                  actual   kind=%0d id=%0d running=%0b error=%0b last=%0b",
                   $time, got.kind, got.timer_id, got.running, got.error, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver throttling
  // ---------------------------------------------------------------------------

  // Random stall bursts, a long hold-off on request, and
  // nothing at all once the run is in its quiet tail.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      out_stall <= 1'b1;
      stall_left <= LONG_HOLD - 1;
    end else if (!quiet && r < 14) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until accepted, predict its results, then
  // maybe leave a gap before the next one.
  task automatic send_request(mode_t mode, logic [HANDLE_W-1:0] handle,
                              logic [PERIOD_W-1:0] period,
                              logic signed [REPEAT_W-1:0] reps);
    int gap;
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_handle       <= handle;
    in_period       <= period;
    in_repeat_count <= reps;
    do @(posedge clk); while (in_stall);
    pool_predict(mode, handle, period, reps);
    gap = 0;
    if (!quiet && sender_gaps && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Random field choices
  // ---------------------------------------------------------------------------

  function automatic mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CMD_TICK;
    if (r < 42) return CMD_CREATE;
    if (r < 57) return CMD_START;
    if (r < 65) return CMD_STOP;
    if (r < 73) return CMD_RESTART;
    if (r < 81) return CMD_RESUME;
    if (r < 90) return CMD_DELETE;
    return CMD_QUERY;
  endfunction

  // Mostly handles of slots in use, so commands reach live timers; some
  // land on free slots and some are out of range.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int live[$];
    int r;
    r = $urandom_range(0, 99);
    for (int s = 0; s < TIMER_SLOTS; s++) begin
      if (pool_used[s]) live.push_back(s + 1);
    end
    if (r < 4) return '0;
    if (r < 10) return HANDLE_W'($urandom_range(TIMER_SLOTS + 1, 31));
    if (r < 25 || live.size() == 0) return HANDLE_W'($urandom_range(1, TIMER_SLOTS));
    return HANDLE_W'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  // Short periods so that timers actually expire, with a few huge ones.
  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return PERIOD_W'($urandom_range(0, 4));
    if (r < 85) return PERIOD_W'($urandom_range(5, 20));
    if (r < 95) return PERIOD_W'($urandom);
    return '1;
  endfunction

  function automatic logic signed [REPEAT_W-1:0] pick_repeats();
    if ($urandom_range(0, 99) < 80) return REPEAT_W'($urandom_range(0, 8) - 3);
    return REPEAT_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill every slot, covering zero and maximum periods, single-shot,
  // forever and extreme repeat counts, then create once more on a full pool.
  task automatic test_fill_pool();
    send_request(CMD_CREATE, '0, 32'd0, 16'sd0);
    send_request(CMD_CREATE, '0, 32'd1, 16'sd1);
    send_request(CMD_CREATE, '1, 32'd2, 16'sd2);
    send_request(CMD_CREATE, '0, 32'hFFFF_FFFF, -16'sd32768);
    send_request(CMD_CREATE, '0, 32'd1, 16'sd32767);
    for (int s = 5; s < TIMER_SLOTS; s++) begin
      send_request(CMD_CREATE, pick_handle(), pick_period(), pick_repeats());
    end
    send_request(CMD_CREATE, '0, 32'd3, 16'sd3);
    wait_drained();
  endtask

  // Each single-timer command on known slots, including the corner cases:
  // a deleted timer keeps its running flag, resume leaves a running timer
  // alone, and out-of-range handles are flagged.
  task automatic test_slot_commands();
    send_request(CMD_START, 5'd1, '0, '0);
    send_request(CMD_START, 5'd2, '0, '0);
    send_request(CMD_START, 5'd3, '1, '1);
    send_request(CMD_RESUME, 5'd4, '0, '0);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_TICK, '1, '1, '1);
    send_request(CMD_QUERY, 5'd2, '0, '0);
    send_request(CMD_DELETE, 5'd1, '0, '0);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_QUERY, 5'd1, '0, '0);
    send_request(CMD_RESTART, 5'd3, '0, '0);
    send_request(CMD_RESUME, 5'd3, '0, '0);
    send_request(CMD_STOP, 5'd4, '0, '0);
    send_request(CMD_START, 5'd0, '0, '0);
    send_request(CMD_QUERY, 5'd31, '0, '0);
    send_request(CMD_CREATE, '0, 32'd0, -16'sd1);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the output register fills and the input side stalls.
  task automatic test_long_hold();
    hold_request = 1'b1;
    for (int h = 1; h <= 6; h++) send_request(CMD_RESTART, HANDLE_W'(h), '0, '0);
    repeat (5) send_request(CMD_TICK, '0, '0, '0);
    wait_drained();
  endtask

  // Random traffic, mostly timer lifecycles (create, start, a few ticks)
  // mixed with loose commands; pauses now and then until fully drained.
  task automatic test_random_commands(int n);
    int sent;
    logic [HANDLE_W-1:0] fresh;
    sent = 0;
    while (sent < n) begin
      if (sent % 20 == 0) sender_gaps = ($urandom_range(0, 3) != 0);
      if (sent % 60 == 59) wait_drained();
      if ($urandom_range(0, 99) < 30) begin
        // The handle that create will hand out is the lowest free slot.
        fresh = '0;
        for (int s = TIMER_SLOTS - 1; s >= 0; s--) begin
          if (!pool_used[s]) fresh = HANDLE_W'(s + 1);
        end
        send_request(CMD_CREATE, pick_handle(), pick_period(), pick_repeats());
        sent++;
        if (fresh != 0) begin
          send_request(($urandom_range(0, 1) != 0) ? CMD_START : CMD_RESUME, fresh,
                       pick_period(), pick_repeats());
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          send_request(CMD_TICK, pick_handle(), pick_period(), pick_repeats());
          sent++;
        end
      end else begin
        send_request(pick_mode(), pick_handle(), pick_period(), pick_repeats());
        sent++;
      end
    end
  endtask

  // Closing stretch with no throttling on either side.
  task automatic test_unthrottled_tail();
    wait_drained();
    quiet = 1'b1;
    test_random_commands(40);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    error_count     = 0;
    cycle_count     = 0;
    quiet           = 1'b0;
    sender_gaps     = 1'b1;
    hold_request    = 1'b0;
    stall_left      = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = CMD_TICK;
    in_handle       = '0;
    in_period       = '0;
    in_repeat_count = '0;
    out_stall       = 1'b0;
    for (int s = 0; s < TIMER_SLOTS; s++) begin
      pool_used[s]    = 1'b0;
      pool_running[s] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_pool();
    test_slot_commands();
    test_long_hold();
    test_random_commands(136);
    test_unthrottled_tail();

    // Let any stray result show up before the verdict.
    wait_drained();
    repeat (TIMER_SLOTS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("multi_channel_soft_timer_pool_tb: clean");
    end else begin
      $display("multi_channel_soft_timer_pool_tb: errors");
    end
    $finish;
  end

endmodule
